// File: rtl/fifo_replacement_id_set_assert.svh
// assertion macros shared by the fifo replacement id set modules
// no dependencies; take in with `include before use
`ifndef FIFO_REPLACEMENT_ID_SET_ASSERT_SVH
`define FIFO_REPLACEMENT_ID_SET_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define FRIS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define FRIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fris_pkg.sv
// shared types and constants of the fifo replacement id set
// no dependencies
package fris_pkg;

    localparam int ID_W      = 32;
    localparam int CAP_W     = 7;
    localparam int OCC_W     = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic CMD_ACCESS  = 1'b0;
    localparam logic CMD_DUMP    = 1'b1;
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef struct packed {
        logic take;
        logic start_search;
        logic start_dump;
        logic step;
        logic load_hit;
        logic load_miss;
        logic load_dump;
        logic load_empty;
        logic clear_store;
    } cmd_t;

    typedef struct packed {
        logic held_zero;
        logic remain_one;
        logic match;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/fifo_replacement_id_set.sv
// top level of the fifo replacement id set (fifo cache tag store)
// depends on fris_pkg, fris_ctrl and fris_datapath
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_command, s_ident
// m_        out        m_valid / m_ready  kind, hit, evicted, entry, occupancy, last
// cfg_      in         cfg_wr_en          cfg_wr_data (capacity)
//
// an access skips the search on an empty store, else ends at a match or the last entry:
// the ring memory has one read port, so entries are compared one per cycle, oldest first
// a dump gives one result per cycle while the output register is free
// reset empties the store at once through the count and pointers; no clearing pass
// a stalled output register holds the controller in its result state; s_ready is idle only
module fifo_replacement_id_set #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fris_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [fris_pkg::ID_W-1:0]         s_ident,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic                              m_hit,
    output logic                              m_evicted_valid,
    output logic [fris_pkg::ID_W-1:0]         m_evicted_ident,
    output logic                              m_entry_valid,
    output logic [fris_pkg::ID_W-1:0]         m_entry_ident,
    output logic [fris_pkg::OCC_W-1:0]        m_occupancy,
    output logic                              m_last
);

    fris_pkg::cmd_t  cmd;
    fris_pkg::stat_t stat;

    fris_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fris_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_ident         (s_ident),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_hit           (m_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_ident (m_evicted_ident),
        .m_entry_valid   (m_entry_valid),
        .m_entry_ident   (m_entry_ident),
        .m_occupancy     (m_occupancy),
        .m_last          (m_last)
    );

endmodule

// File: rtl/fris_ctrl.sv
// controller state machine of the fifo replacement id set
// depends on fris_pkg and fifo_replacement_id_set_assert.svh
`include "fifo_replacement_id_set_assert.svh"

module fris_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_command,
    output logic              s_ready,
    input  fris_pkg::stat_t   stat,
    output fris_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_SEARCH     = 6'b000010,
        ST_ACC_HIT    = 6'b000100,
        ST_ACC_MISS   = 6'b001000,
        ST_DUMP       = 6'b010000,
        ST_DUMP_EMPTY = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (s_command == fris_pkg::CMD_DUMP) begin
                        if (stat.held_zero) begin
                            state_next = ST_DUMP_EMPTY;
                        end else begin
                            cmd.start_dump = 1'b1;
                            state_next     = ST_DUMP;
                        end
                    end else begin
                        if (stat.held_zero) begin
                            state_next = ST_ACC_MISS;
                        end else begin
                            cmd.start_search = 1'b1;
                            state_next       = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (stat.match) begin
                    state_next = ST_ACC_HIT;
                end else if (stat.remain_one) begin
                    state_next = ST_ACC_MISS;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_ACC_HIT: begin
                if (stat.out_free) begin
                    cmd.load_hit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ACC_MISS: begin
                if (stat.out_free) begin
                    cmd.load_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (stat.out_free) begin
                    cmd.load_dump = 1'b1;
                    if (stat.remain_one) begin
                        cmd.clear_store = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_DUMP_EMPTY: begin
                if (stat.out_free) begin
                    cmd.load_empty  = 1'b1;
                    cmd.clear_store = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `FRIS_ASSERT_NOW(a_load_only_when_free, aclk, aresetn, cmd.load_hit || cmd.load_miss || cmd.load_dump || cmd.load_empty, stat.out_free, "result loaded while output busy")
    `FRIS_ASSERT_NOW(a_no_step_past_end, aclk, aresetn, cmd.step, !stat.remain_one, "scan stepped past the last entry")
    `FRIS_ASSERT_NEXT(a_take_leaves_idle, aclk, aresetn, cmd.take, !s_ready, "accepted item did not start work")

endmodule

// File: rtl/fris_datapath.sv
// datapath of the fifo replacement id set: ident ring memory, pointers, output register
// depends on fris_pkg and fifo_replacement_id_set_assert.svh
`include "fifo_replacement_id_set_assert.svh"

module fris_datapath #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fris_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic [fris_pkg::ID_W-1:0]         s_ident,
    input  fris_pkg::cmd_t                    cmd,
    output fris_pkg::stat_t                   stat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic                              m_hit,
    output logic                              m_evicted_valid,
    output logic [fris_pkg::ID_W-1:0]         m_evicted_ident,
    output logic                              m_entry_valid,
    output logic [fris_pkg::ID_W-1:0]         m_entry_ident,
    output logic [fris_pkg::OCC_W-1:0]        m_occupancy,
    output logic                              m_last
);

    localparam int PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_ENTRIES - 1);
    localparam logic [fris_pkg::CAP_W-1:0] CAP_MAX = fris_pkg::CAP_W'(MAX_ENTRIES);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    logic [fris_pkg::ID_W-1:0] ring_mem [MAX_ENTRIES];

    logic [fris_pkg::CAP_W-1:0] capacity_reg;
    logic [PTR_W-1:0]           oldest_reg, oldest_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]           held_reg, held_next;
    logic [PTR_W-1:0]           scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]           remain_reg, remain_next;
    logic                       down_reg, down_next;
    logic                       first_reg, first_next;
    logic [fris_pkg::ID_W-1:0]  ident_reg;
    logic [fris_pkg::ID_W-1:0]  evict_id_reg;
    logic [fris_pkg::ID_W-1:0]  rd_data_reg;

    logic                       m_valid_reg;
    logic                       m_kind_reg, m_hit_reg, m_evicted_valid_reg;
    logic                       m_entry_valid_reg, m_last_reg;
    logic [fris_pkg::ID_W-1:0]  m_evicted_ident_reg, m_entry_ident_reg;
    logic [fris_pkg::OCC_W-1:0] m_occupancy_reg;

    logic [fris_pkg::CAP_W-1:0] eff_cap;
    logic [PTR_W-1:0]           newest;
    logic [PTR_W-1:0]           rd_addr;
    logic                       rd_en;
    logic                       evict;
    logic                       out_free;

    assign eff_cap = (capacity_reg == '0) ? fris_pkg::CAP_W'(1) :
                     ((capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg);
    assign newest   = ptr_dec(tail_reg);
    assign evict    = (fris_pkg::CAP_W'(held_reg) >= eff_cap);
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = cmd.start_search || cmd.start_dump || cmd.step;

    always_comb begin
        if (cmd.start_search) begin
            rd_addr = oldest_reg;
        end else if (cmd.start_dump) begin
            rd_addr = newest;
        end else begin
            rd_addr = scan_ptr_reg;
        end
    end

    assign stat.held_zero  = (held_reg == '0);
    assign stat.remain_one = (remain_reg == CNT_W'(1));
    assign stat.match      = (rd_data_reg == ident_reg);
    assign stat.out_free   = out_free;

    // scan control and store pointers
    always_comb begin
        scan_ptr_next = scan_ptr_reg;
        remain_next   = remain_reg;
        down_next     = down_reg;
        first_next    = first_reg;
        oldest_next   = oldest_reg;
        tail_next     = tail_reg;
        held_next     = held_reg;
        if (cmd.start_search) begin
            scan_ptr_next = ptr_inc(oldest_reg);
            remain_next   = held_reg;
            down_next     = 1'b0;
            first_next    = 1'b1;
        end else if (cmd.start_dump) begin
            scan_ptr_next = ptr_dec(newest);
            remain_next   = held_reg;
            down_next     = 1'b1;
            first_next    = 1'b1;
        end else if (cmd.step) begin
            scan_ptr_next = down_reg ? ptr_dec(scan_ptr_reg) : ptr_inc(scan_ptr_reg);
            remain_next   = remain_reg - CNT_W'(1);
            first_next    = 1'b0;
        end
        if (cmd.load_miss) begin
            tail_next = ptr_inc(tail_reg);
            if (evict) begin
                oldest_next = ptr_inc(oldest_reg);
            end else begin
                held_next = held_reg + CNT_W'(1);
            end
        end
        if (cmd.clear_store || cfg_wr_en) begin
            oldest_next = '0;
            tail_next   = '0;
            held_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= fris_pkg::CAP_RESET;
            oldest_reg   <= '0;
            tail_reg     <= '0;
            held_reg     <= '0;
            scan_ptr_reg <= '0;
            remain_reg   <= '0;
            down_reg     <= 1'b0;
            first_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            oldest_reg   <= oldest_next;
            tail_reg     <= tail_next;
            held_reg     <= held_next;
            scan_ptr_reg <= scan_ptr_next;
            remain_reg   <= remain_next;
            down_reg     <= down_next;
            first_reg    <= first_next;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load_miss) begin
            ring_mem[tail_reg] <= ident_reg;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            ident_reg <= s_ident;
        end
        // the first entry read in a search is the oldest
        if (first_reg) begin
            evict_id_reg <= rd_data_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_hit || cmd.load_miss || cmd.load_dump || cmd.load_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_hit) begin
            m_kind_reg          <= fris_pkg::KIND_ACCESS;
            m_hit_reg           <= 1'b1;
            m_evicted_valid_reg <= 1'b0;
            m_evicted_ident_reg <= '0;
            m_entry_valid_reg   <= 1'b0;
            m_entry_ident_reg   <= '0;
            m_occupancy_reg     <= fris_pkg::OCC_W'(held_reg);
            m_last_reg          <= 1'b1;
        end else if (cmd.load_miss) begin
            m_kind_reg          <= fris_pkg::KIND_ACCESS;
            m_hit_reg           <= 1'b0;
            m_evicted_valid_reg <= evict;
            m_evicted_ident_reg <= evict ? evict_id_reg : '0;
            m_entry_valid_reg   <= 1'b0;
            m_entry_ident_reg   <= '0;
            m_occupancy_reg     <= fris_pkg::OCC_W'(held_next);
            m_last_reg          <= 1'b1;
        end else if (cmd.load_dump) begin
            m_kind_reg          <= fris_pkg::KIND_DUMP;
            m_hit_reg           <= 1'b0;
            m_evicted_valid_reg <= 1'b0;
            m_evicted_ident_reg <= '0;
            m_entry_valid_reg   <= 1'b1;
            m_entry_ident_reg   <= rd_data_reg;
            m_occupancy_reg     <= fris_pkg::OCC_W'(held_reg);
            m_last_reg          <= (remain_reg == CNT_W'(1));
        end else if (cmd.load_empty) begin
            m_kind_reg          <= fris_pkg::KIND_DUMP;
            m_hit_reg           <= 1'b0;
            m_evicted_valid_reg <= 1'b0;
            m_evicted_ident_reg <= '0;
            m_entry_valid_reg   <= 1'b0;
            m_entry_ident_reg   <= '0;
            m_occupancy_reg     <= '0;
            m_last_reg          <= 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_hit           = m_hit_reg;
    assign m_evicted_valid = m_evicted_valid_reg;
    assign m_evicted_ident = m_evicted_ident_reg;
    assign m_entry_valid   = m_entry_valid_reg;
    assign m_entry_ident   = m_entry_ident_reg;
    assign m_occupancy     = m_occupancy_reg;
    assign m_last          = m_last_reg;

    `FRIS_ASSERT_NOW(a_held_within_cap, aclk, aresetn, 1'b1, fris_pkg::CAP_W'(held_reg) <= eff_cap, "held count above capacity")
    `FRIS_ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.clear_store || cfg_wr_en, held_reg == '0, "store not empty after clear")
    `FRIS_ASSERT_NEXT(a_load_shows_valid, aclk, aresetn, cmd.load_hit || cmd.load_miss || cmd.load_dump || cmd.load_empty, m_valid_reg, "loaded item not presented")

endmodule

// File: tb/sv/fifo_replacement_id_set_test.sv
`timescale 1ns / 100ps
// testbench of the fifo replacement id set: a directed table, then random phases
// needs fris_pkg and fifo_replacement_id_set; every result is checked in order against
// the table or a predictor held in this file, with random idling on both channels

module fifo_replacement_id_set_test;

    localparam int MAX_ENTRIES    = 64;
    localparam int NUM_DIRECTED   = 25;
    localparam int NUM_PHASES     = 4;
    localparam int CFG_SETTLE     = 4;
    localparam int END_SETTLE     = 70;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [fris_pkg::CAP_W-1:0] PHASE_CAP [NUM_PHASES] =
        '{7'd3, 7'd1, 7'd64, 7'd127};
    localparam int PHASE_ITEMS    [NUM_PHASES] = '{40, 25, 90, 45};
    localparam int PHASE_HIT_PCT  [NUM_PHASES] = '{35, 30, 10, 30};
    localparam int PHASE_DUMP_PCT [NUM_PHASES] = '{5, 8, 0, 3};
    localparam int PHASE_SND_IDLE [NUM_PHASES] = '{22, 59, 59, 0};
    localparam int PHASE_RCV_IDLE [NUM_PHASES] = '{59, 22, 22, 0};
    localparam bit PHASE_HOLD     [NUM_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic                       kind;
        logic                       hit;
        logic                       evicted_valid;
        logic [fris_pkg::ID_W-1:0]  evicted_ident;
        logic                       entry_valid;
        logic [fris_pkg::ID_W-1:0]  entry_ident;
        logic [fris_pkg::OCC_W-1:0] occupancy;
        logic                       last;
    } id_set_result_t;

    typedef struct packed {
        logic                       set_cap;
        logic [fris_pkg::CAP_W-1:0] cap;
        logic                       command;
        logic [fris_pkg::ID_W-1:0]  ident;
        logic                       typed;
        id_set_result_t             res;
    } directed_row_t;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [fris_pkg::CAP_W-1:0] cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic                       s_command   = fris_pkg::CMD_ACCESS;
    logic [fris_pkg::ID_W-1:0]  s_ident     = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic                       m_kind;
    logic                       m_hit;
    logic                       m_evicted_valid;
    logic [fris_pkg::ID_W-1:0]  m_evicted_ident;
    logic                       m_entry_valid;
    logic [fris_pkg::ID_W-1:0]  m_entry_ident;
    logic [fris_pkg::OCC_W-1:0] m_occupancy;
    logic                       m_last;

    // predictor state: held identifiers, oldest first
    logic [fris_pkg::ID_W-1:0]  held_ids [$];
    logic [fris_pkg::CAP_W-1:0] cap_reg = fris_pkg::CAP_RESET;
    id_set_result_t             step_results [$];
    id_set_result_t             pending_results [$];

    int error_count   = 0;
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    fifo_replacement_id_set #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_ident        (s_ident),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_hit          (m_hit),
        .m_evicted_valid(m_evicted_valid),
        .m_evicted_ident(m_evicted_ident),
        .m_entry_valid  (m_entry_valid),
        .m_entry_ident  (m_entry_ident),
        .m_occupancy    (m_occupancy),
        .m_last         (m_last)
    );

    always #1 aclk = ~aclk;

    function automatic id_set_result_t access_result(input logic hit, input logic ev_valid,
                                                      input logic [fris_pkg::ID_W-1:0] ev_ident,
                                                      input logic [fris_pkg::OCC_W-1:0] occ);
        id_set_result_t res;
        res               = '0;
        res.kind          = fris_pkg::KIND_ACCESS;
        res.hit           = hit;
        res.evicted_valid = ev_valid;
        res.evicted_ident = ev_ident;
        res.occupancy     = occ;
        res.last          = 1'b1;
        return res;
    endfunction

    function automatic id_set_result_t dump_result(input logic en_valid,
                                                    input logic [fris_pkg::ID_W-1:0] en_ident,
                                                    input logic [fris_pkg::OCC_W-1:0] occ,
                                                    input logic last);
        id_set_result_t res;
        res             = '0;
        res.kind        = fris_pkg::KIND_DUMP;
        res.entry_valid = en_valid;
        res.entry_ident = en_ident;
        res.occupancy   = occ;
        res.last        = last;
        return res;
    endfunction

    function automatic void predict_id_set(input logic cmd,
                                           input logic [fris_pkg::ID_W-1:0] ident);
        int                        n;
        int                        limit;
        bit                        found;
        bit                        evicted;
        logic [fris_pkg::ID_W-1:0] victim;
        step_results.delete();
        n = held_ids.size();
        if (cmd == fris_pkg::CMD_DUMP) begin
            if (n == 0) begin
                step_results.insert(step_results.size(), dump_result(1'b0, '0, '0, 1'b1));
            end
            for (int i = n - 1; i >= 0; i--) begin
                step_results.insert(step_results.size(),
                                    dump_result(1'b1, held_ids[i],
                                                fris_pkg::OCC_W'(n), i == 0));
            end
            held_ids.delete();
        end else begin
            found = 1'b0;
            foreach (held_ids[i]) begin
                if (held_ids[i] == ident) found = 1'b1;
            end
            if (found) begin
                step_results.insert(step_results.size(),
                                    access_result(1'b1, 1'b0, '0, fris_pkg::OCC_W'(n)));
            end else begin
                limit   = (cap_reg == 0) ? 1 :
                          ((cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg));
                evicted = (n >= limit);
                victim  = '0;
                if (evicted) victim = held_ids.pop_front();
                held_ids.insert(held_ids.size(), ident);
                step_results.insert(step_results.size(),
                                    access_result(1'b0, evicted, victim,
                                                  fris_pkg::OCC_W'(held_ids.size())));
            end
        end
    endfunction

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // empty store after reset, identifier extremes, capacity at reset value
        '{1'b0, 7'd0,   fris_pkg::CMD_DUMP,   32'h0000_0000, 1'b1,
          dump_result(1'b0, '0, 7'd0, 1'b1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0000, 1'b1,
          access_result(1'b0, 1'b0, '0, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'hffff_ffff, 1'b1,
          access_result(1'b0, 1'b0, '0, 7'd2)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0000, 1'b1,
          access_result(1'b1, 1'b0, '0, 7'd2)},
        '{1'b0, 7'd0,   fris_pkg::CMD_DUMP,   32'hffff_ffff, 1'b0, '0},
        // capacity zero behaves as one
        '{1'b1, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h1234_5678, 1'b1,
          access_result(1'b0, 1'b0, '0, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'ha5a5_a5a5, 1'b1,
          access_result(1'b0, 1'b1, 32'h1234_5678, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'ha5a5_a5a5, 1'b1,
          access_result(1'b1, 1'b0, '0, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h5a5a_5a5a, 1'b1,
          access_result(1'b0, 1'b1, 32'ha5a5_a5a5, 7'd1)},
        // capacity above the maximum saturates, and the write empties the store
        '{1'b1, 7'd127, fris_pkg::CMD_ACCESS, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'hffff_ffff, 1'b1,
          access_result(1'b0, 1'b0, '0, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_DUMP,   32'h0000_0000, 1'b1,
          dump_result(1'b1, 32'hffff_ffff, 7'd1, 1'b1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_DUMP,   32'hffff_ffff, 1'b1,
          dump_result(1'b0, '0, 7'd0, 1'b1)},
        // small capacity: eviction order and hits after eviction
        '{1'b1, 7'd2,   fris_pkg::CMD_ACCESS, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0002, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0003, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0002, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_DUMP,   32'h0000_0000, 1'b0, '0},
        '{1'b1, 7'd1,   fris_pkg::CMD_ACCESS, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0007, 1'b1,
          access_result(1'b0, 1'b0, '0, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_ACCESS, 32'h0000_0008, 1'b1,
          access_result(1'b0, 1'b1, 32'h0000_0007, 7'd1)},
        '{1'b0, 7'd0,   fris_pkg::CMD_DUMP,   32'h0000_0000, 1'b0, '0}
    };

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [fris_pkg::ID_W-1:0] seen,
                               input logic [fris_pkg::ID_W-1:0] want);
        if (seen !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, want));
        end
    endtask

    // stops offering, waits for every outstanding result, then lets the block settle
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [fris_pkg::CAP_W-1:0] value);
        drain(CFG_SETTLE);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = value;
        held_ids.delete();
    endtask

    task automatic send_item(input logic cmd, input logic [fris_pkg::ID_W-1:0] ident,
                             input logic typed, input id_set_result_t typed_res);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        predict_id_set(cmd, ident);
        if (typed) begin
            pending_results.insert(pending_results.size(), typed_res);
        end else begin
            foreach (step_results[i]) begin
                pending_results.insert(pending_results.size(), step_results[i]);
            end
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_ident   <= ident;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_monitor
        id_set_result_t seen;
        id_set_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            seen = '{m_kind, m_hit, m_evicted_valid, m_evicted_ident, m_entry_valid,
                     m_entry_ident, m_occupancy, m_last};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("item with no expectation waiting: %h", seen));
            end else begin
                want = pending_results.pop_front();
                check_field("kind", fris_pkg::ID_W'(seen.kind), fris_pkg::ID_W'(want.kind));
                check_field("hit", fris_pkg::ID_W'(seen.hit), fris_pkg::ID_W'(want.hit));
                check_field("evicted_valid", fris_pkg::ID_W'(seen.evicted_valid),
                            fris_pkg::ID_W'(want.evicted_valid));
                check_field("evicted_ident", seen.evicted_ident, want.evicted_ident);
                check_field("entry_valid", fris_pkg::ID_W'(seen.entry_valid),
                            fris_pkg::ID_W'(want.entry_valid));
                check_field("entry_ident", seen.entry_ident, want.entry_ident);
                check_field("occupancy", fris_pkg::ID_W'(seen.occupancy),
                            fris_pkg::ID_W'(want.occupancy));
                check_field("last", fris_pkg::ID_W'(seen.last), fris_pkg::ID_W'(want.last));
            end
        end
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fifo_replacement_id_set_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                        r;
        logic                      cmd;
        logic [fris_pkg::ID_W-1:0] ident;
        snd_idle_pct = PHASE_SND_IDLE[0];
        rcv_idle_pct = PHASE_RCV_IDLE[0];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_cap) begin
                write_capacity(directed_rows[i].cap);
            end else begin
                send_item(directed_rows[i].command, directed_rows[i].ident,
                          directed_rows[i].typed, directed_rows[i].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(PHASE_CAP[p]);
            snd_idle_pct = PHASE_SND_IDLE[p];
            rcv_idle_pct = PHASE_RCV_IDLE[p];
            if (PHASE_HOLD[p]) hold_requests <= hold_requests + 1;
            for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
                r     = $urandom_range(0, 99);
                cmd   = fris_pkg::CMD_ACCESS;
                ident = $urandom;
                if (r < PHASE_DUMP_PCT[p]) begin
                    cmd = fris_pkg::CMD_DUMP;
                end else if (r < PHASE_DUMP_PCT[p] + PHASE_HIT_PCT[p] &&
                             held_ids.size() != 0) begin
                    ident = held_ids[$urandom_range(0, held_ids.size() - 1)];
                end else if (r < PHASE_DUMP_PCT[p] + PHASE_HIT_PCT[p] + 15) begin
                    // small values come back after eviction
                    ident = $urandom_range(0, 15);
                end
                send_item(cmd, ident, 1'b0, '0);
            end
            send_item(fris_pkg::CMD_DUMP, $urandom, 1'b0, '0);
        end

        drain(END_SETTLE);
        if (error_count == 0) begin
            $display("fifo_replacement_id_set_test: clean");
        end else begin
            $display("fifo_replacement_id_set_test: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/fris_pkg.sv
rtl/fris_ctrl.sv
rtl/fris_datapath.sv
rtl/fifo_replacement_id_set.sv
tb/sv/fifo_replacement_id_set_test.sv
